// File: rtl/mhbs_pkg.sv
// ============================================================================
// mhbs_pkg - shared constants and helpers for the murmur2 bucket selector
// 32-bit MurmurHash2 mixing constants, register indexes, sequencer states
// and the one-bit restoring remainder step.
// ============================================================================
package mhbs_pkg;

  localparam int unsigned HASH_W        = 32;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned KLEN_W        = 8;
  localparam int unsigned MAX_KEY_BYTES = 255;

  localparam logic [HASH_W-1:0] MIX_MUL    = 32'h5bd1_e995;
  localparam int unsigned       MIX_SHIFT  = 24;
  localparam int unsigned       FIN_SHIFT1 = 13;
  localparam int unsigned       FIN_SHIFT2 = 15;

  localparam logic [HASH_W-1:0] RESET_SEED    = 32'h1234_abcd;
  localparam logic [CNT_W-1:0]  RESET_SERVERS = 5'd2;
  localparam logic [CNT_W-1:0]  MAX_SERVERS   = 5'd16;

  // configuration register indexes
  localparam logic CFG_IDX_SEED    = 1'b0;
  localparam logic CFG_IDX_SERVERS = 1'b1;

  // remainder: four hash bits per cycle, MSB first
  localparam int unsigned MOD_BITS  = 4;
  localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLK_K1,
    ST_BLK_K2,
    ST_BLK_H,
    ST_TAIL,
    ST_FIN_MUL,
    ST_FIN_XOR,
    ST_MOD,
    ST_OUT
  } state_t;

  // one restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [IDX_W-1:0] mod_step(logic [IDX_W-1:0] rem,
                                                 logic bit_in,
                                                 logic [CNT_W-1:0] div);
    logic [CNT_W-1:0] t;
    t = {rem, bit_in};
    if (t >= div) begin
      t = t - div;
    end
    return t[IDX_W-1:0];
  endfunction

endpackage

// File: rtl/murmur2_hash_bucket_select.sv
// ============================================================================
// murmur2_hash_bucket_select - MurmurHash2 key hasher with bucket select
// Hashes a key given as 32-bit little-endian words with a shared constant
// multiplier, then reduces the hash modulo the server count, clamped to 1..16.
// ============================================================================
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | data_word, valid_bytes,
//           |           |                    | last_word, key_length
//   out_    | output    | out_valid/out_stall| bucket, hash_value
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A full word is accepted and then takes three passes through the one
// 32x32 constant multiplier; a short tail word is mixed in the tail state.
// An empty word is only accepted. After the last word come the final mix
// multiply, the final xor, the radix-16 remainder steps and the output load.
// in_stall is high while the sequencer works; a held result on out_ stalls
// the sequencer in its output state only. Synchronous reset, active low.
module murmur2_hash_bucket_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  input  logic [7:0]  in_key_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_bucket,
  output logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import mhbs_pkg::*;

  state_t state_r, state_nxt;

  logic [HASH_W-1:0]    seed_r;
  logic [CNT_W-1:0]     servers_r;
  logic                 in_key_r, in_key_nxt;
  logic [HASH_W-1:0]    h_r, h_nxt;
  logic [HASH_W-1:0]    k_r, k_nxt;
  logic [1:0]           nb_r, nb_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [HASH_W-1:0]    out_hash_r, out_hash_nxt;

  logic              in_acc;
  logic              out_free;
  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] mul_p;
  logic [HASH_W-1:0] tail_mask;
  logic [KLEN_W-1:0] klen_clamp;
  logic [CNT_W-1:0]  div_eff;
  logic [IDX_W-1:0]  rem_chain;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_bucket     = out_idx_r;
  assign out_hash_value = out_hash_r;

  assign klen_clamp = (32'(in_key_length) > MAX_KEY_BYTES) ?
                      KLEN_W'(MAX_KEY_BYTES) : in_key_length;

  always_comb begin
    if (servers_r == '0) begin
      div_eff = CNT_W'(1);
    end else if (servers_r > MAX_SERVERS) begin
      div_eff = MAX_SERVERS;
    end else begin
      div_eff = servers_r;
    end
  end

  always_comb begin
    unique case (nb_r)
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h00ff_ffff;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_BLK_K1:  mul_a = k_r;
      ST_BLK_K2:  mul_a = k_r ^ (k_r >> MIX_SHIFT);
      ST_BLK_H:   mul_a = h_r;
      ST_TAIL:    mul_a = h_r ^ (k_r & tail_mask);
      ST_FIN_MUL: mul_a = h_r ^ (h_r >> FIN_SHIFT1);
      default:    mul_a = h_r;
    endcase
  end

  assign mul_p = mul_a * MIX_MUL;

  always_comb begin
    rem_chain = rem_r;
    for (int i = 0; i < MOD_BITS; i++) begin
      rem_chain = mod_step(rem_chain, k_r[HASH_W-1-i], div_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_key_nxt    = in_key_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_hash_nxt  = out_hash_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          k_nxt      = in_data_word;
          nb_nxt     = in_valid_bytes[1:0];
          last_nxt   = in_last_word;
          in_key_nxt = !in_last_word;
          if (!in_key_r) begin
            h_nxt = seed_r ^ HASH_W'(klen_clamp);
          end
          priority if (in_valid_bytes >= 3'd4) begin
            state_nxt = ST_BLK_K1;
          end else if (in_valid_bytes != 3'd0) begin
            state_nxt = ST_TAIL;
          end else if (in_last_word) begin
            state_nxt = ST_FIN_MUL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BLK_K1: begin
        k_nxt     = mul_p;
        state_nxt = ST_BLK_K2;
      end
      ST_BLK_K2: begin
        k_nxt     = mul_p;
        state_nxt = ST_BLK_H;
      end
      ST_BLK_H: begin
        h_nxt     = mul_p ^ k_r;
        state_nxt = last_r ? ST_FIN_MUL : ST_IDLE;
      end
      ST_TAIL: begin
        h_nxt     = mul_p;
        state_nxt = last_r ? ST_FIN_MUL : ST_IDLE;
      end
      ST_FIN_MUL: begin
        h_nxt     = mul_p;
        state_nxt = ST_FIN_XOR;
      end
      ST_FIN_XOR: begin
        // k_r becomes the MSB-first shifter for the remainder
        h_nxt     = h_r ^ (h_r >> FIN_SHIFT2);
        k_nxt     = h_r ^ (h_r >> FIN_SHIFT2);
        div_nxt   = div_eff;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        rem_nxt = rem_chain;
        k_nxt   = k_r << MOD_BITS;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output word is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = rem_r;
          out_hash_nxt  = h_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= RESET_SEED;
      servers_r   <= RESET_SERVERS;
    end else begin
      state_r     <= state_nxt;
      in_key_r    <= in_key_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IDX_SEED:    seed_r    <= cfg_data;
          CFG_IDX_SERVERS: servers_r <= cfg_data[CNT_W-1:0];
          default:         seed_r    <= seed_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    k_r        <= k_nxt;
    nb_r       <= nb_nxt;
    last_r     <= last_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule

// File: rtl/mhbs_checker.sv
// ============================================================================
// mhbs_checker - port-level checks for the murmur2 bucket selector
// Watches the top level's ports and flags handshake and sequencing slips.
// ============================================================================
module mhbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_valid_bytes,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_bucket,
  input logic [31:0] out_hash_value
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash_value)
                               && $stable(out_bucket))
    else $error("stalled result word changed");

  // a last word always leads on to the final mix, so input must stall next
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_word |=> in_stall)
    else $error("no busy period after last word");

  // a new result only comes out of the busy sequencer
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // a full word keeps the sequencer busy after it is accepted
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_valid_bytes >= 3'd4) |=> in_stall ##1 in_stall)
    else $error("full word finished too early");

endmodule

bind murmur2_hash_bucket_select mhbs_checker u_mhbs_checker (.*);

// File: tb/murmur2_hash_bucket_select_test.sv
// ============================================================================
// murmur2_hash_bucket_select_test - self-checking bench for the key hasher
// Sends keys as little-endian words through the in_ channel, predicts the
// MurmurHash2 value and bucket of every key, and checks each word on out_.
// Seed and server count are rewritten between keys once results drain. Both sides idle and
// stall at random.
// ============================================================================
module murmur2_hash_bucket_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mhbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 800_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned RANDOM_WORDS = 1880;

  typedef struct packed {
    logic [IDX_W-1:0]  bucket;
    logic [HASH_W-1:0] hash;
  } bucket_pick_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_data_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic [7:0]  in_key_length;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_bucket;
  logic [31:0] out_hash_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // predictor state
  bucket_pick_t      expected_picks[$];
  logic [HASH_W-1:0] seed_reg;
  logic [CNT_W-1:0]  servers_reg;
  logic [HASH_W-1:0] hash_acc;
  logic              key_open;

  int mismatches;
  int words_sent;
  bit no_idle;
  int hold_left;

  murmur2_hash_bucket_select dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .in_key_length  (in_key_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bucket     (out_bucket),
    .out_hash_value (out_hash_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] murmur_block(logic [31:0] h, logic [31:0] k);
    k = k * MIX_MUL;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_MUL;
    h = h * MIX_MUL;
    return h ^ k;
  endfunction

  function automatic logic [31:0] murmur_tail(logic [31:0] h, logic [31:0] w,
                                              logic [2:0] nbytes);
    logic [31:0] mask;
    mask = (32'h1 << (8 * nbytes)) - 32'h1;
    h = h ^ (w & mask);
    return h * MIX_MUL;
  endfunction

  function automatic logic [31:0] avalanche(logic [31:0] h);
    h = h ^ (h >> FIN_SHIFT1);
    h = h * MIX_MUL;
    return h ^ (h >> FIN_SHIFT2);
  endfunction

  function automatic logic [IDX_W-1:0] bucket_of(logic [31:0] h);
    logic [31:0] count;
    logic [31:0] rem;
    count = {27'b0, servers_reg};
    if (count == 0) count = 1;
    if (count > MAX_SERVERS) count = MAX_SERVERS;
    rem = h % count;
    return rem[IDX_W-1:0];
  endfunction

  task automatic hash_word(logic [31:0] data, logic [2:0] nbytes, logic last,
                           logic [7:0] klen);
    logic [31:0]  len32;
    bucket_pick_t pick;
    if (!key_open) begin
      len32 = {24'b0, klen};
      if (len32 > MAX_KEY_BYTES) len32 = MAX_KEY_BYTES;
      hash_acc = seed_reg ^ len32;
      key_open = 1'b1;
    end
    if (nbytes >= 3'd4) begin
      hash_acc = murmur_block(hash_acc, data);
    end else if (nbytes != 3'd0) begin
      hash_acc = murmur_tail(hash_acc, data, nbytes);
    end
    if (last) begin
      pick.hash   = avalanche(hash_acc);
      pick.bucket = bucket_of(pick.hash);
      expected_picks.push_back(pick);
      hash_acc = '0;
      key_open = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $realtime, field,
               want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    bucket_pick_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result word: bucket %0d hash 0x%08h", $realtime,
                   out_bucket, out_hash_value);
        end
      end else begin
        want = expected_picks.pop_front();
        if (out_hash_value !== want.hash) begin
          report_mismatch("hash_value", want.hash, out_hash_value);
        end
        if (out_bucket !== want.bucket) begin
          report_mismatch("bucket", {28'b0, want.bucket}, {28'b0, out_bucket});
        end
      end
    end
  end

  // ---------------------------------------------------------------- idling
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_receiver
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b0;
        free_left  = $urandom_range(0, 12);
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------- sending
  task automatic send_word(logic [31:0] data, logic [2:0] nbytes, logic last,
                           logic [7:0] klen);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_data_word   <= data;
    in_valid_bytes <= nbytes;
    in_last_word   <= last;
    in_key_length  <= klen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_word(data, nbytes, last, klen);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_IDX_SEED) begin
      seed_reg = value;
    end else begin
      servers_reg = value[CNT_W-1:0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_key_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 16);
    if (r < 95) return $urandom_range(17, 64);
    return $urandom_range(65, 255);
  endfunction

  // noisy keys carry odd byte counts, stray empty words and wrong lengths
  task automatic send_key(int len, bit noisy);
    int         nwords;
    int         tail_bytes;
    logic [7:0] klen;
    logic [2:0] nbytes;
    logic       last;
    nwords     = (len == 0) ? 1 : (len + 3) / 4;
    tail_bytes = (len == 0) ? 0 : ((len % 4 == 0) ? 4 : len % 4);
    klen       = len[7:0];
    if (noisy && $urandom_range(0, 3) == 0) klen = 8'($urandom);
    for (int w = 0; w < nwords; w++) begin
      last   = (w == nwords - 1);
      nbytes = last ? tail_bytes[2:0] : 3'd4;
      if (noisy && $urandom_range(0, 4) == 0) nbytes = 3'($urandom_range(0, 7));
      if (noisy && !last && $urandom_range(0, 7) == 0) begin
        send_word($urandom, 3'd0, 1'b0, 8'($urandom));
      end
      send_word($urandom, nbytes, last, (w == 0) ? klen : 8'($urandom));
    end
  endtask

  task automatic write_random_config();
    logic [31:0] value;
    int          r;
    write_reg(CFG_IDX_SEED, $urandom);
    value = $urandom;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      value[4:0] = 5'd0;
    end else if (r == 1) begin
      value[4:0] = 5'($urandom_range(17, 31));
    end else begin
      value[4:0] = 5'($urandom_range(1, 16));
    end
    write_reg(CFG_IDX_SERVERS, value);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    // empty keys, with and without a matching length
    send_word(32'h0000_0000, 3'd0, 1'b1, 8'd0);
    send_word(32'hffff_ffff, 3'd0, 1'b1, 8'hff);
    // one to four byte keys
    send_word(32'h0000_0000, 3'd1, 1'b1, 8'd1);
    send_word(32'hffff_ffff, 3'd2, 1'b1, 8'd2);
    send_word(32'h00ab_cdef, 3'd3, 1'b1, 8'd3);
    send_word(32'hffff_ffff, 3'd4, 1'b1, 8'd4);
    send_word(32'h0000_0000, 3'd4, 1'b1, 8'd4);
    // two words, full then tail
    send_word(32'h1234_5678, 3'd4, 1'b0, 8'd7);
    send_word(32'hffff_ffff, 3'd3, 1'b1, 8'd0);
    // byte counts above four count as a full block
    send_word($urandom, 3'd5, 1'b1, 8'd4);
    send_word($urandom, 3'd6, 1'b1, 8'd4);
    send_word($urandom, 3'd7, 1'b1, 8'd4);
    // short word ahead of the last one
    send_word($urandom, 3'd2, 1'b0, 8'd6);
    send_word($urandom, 3'd4, 1'b1, 8'd0);
    // empty word in the middle of a key
    send_word($urandom, 3'd0, 1'b0, 8'd4);
    send_word($urandom, 3'd4, 1'b1, 8'd0);
    // lengths that do not match the words
    send_word($urandom, 3'd4, 1'b1, 8'd0);
    send_word($urandom, 3'd4, 1'b0, 8'hff);
    send_word($urandom, 3'd1, 1'b1, 8'd9);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    logic [31:0] seeds[6];
    logic [4:0]  counts[6];
    seeds  = '{32'h0000_0000, 32'hffff_ffff, RESET_SEED, $urandom, $urandom, $urandom};
    counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'($urandom_range(2, 15))};
    foreach (seeds[i]) begin
      write_reg(CFG_IDX_SEED, seeds[i]);
      write_reg(CFG_IDX_SERVERS, {27'b0, counts[i]});
      repeat (6) send_key(pick_key_len() % 24, 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_IDX_SERVERS, 32'd7);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    no_idle   = 1'b1;
    // keep offering while the result side holds off
    repeat (16) send_key($urandom_range(1, 8), 1'b0);
    no_idle = 1'b0;
    wait_drained();
    repeat (8) send_key($urandom_range(0, 12), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_keys();
    int nkeys;
    nkeys = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (nkeys % 30 == 29) write_random_config();
      // a stretch with no idling on either side now and then
      if (nkeys % 50 == 10) no_idle = 1'b1;
      if (nkeys % 50 == 25) no_idle = 1'b0;
      send_key(pick_key_len(), $urandom_range(0, 4) == 0);
      nkeys++;
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_word   = '0;
    in_valid_bytes = '0;
    in_last_word   = 1'b0;
    in_key_length  = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_IDX_SEED;
    cfg_data       = '0;
    seed_reg       = RESET_SEED;
    servers_reg    = RESET_SERVERS;
    hash_acc       = '0;
    key_open       = 1'b0;
    mismatches     = 0;
    words_sent     = 0;
    no_idle        = 1'b0;
    hold_left      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_keys();

    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
